// File: hdl/attsf_pkg.sv
// Shared types and constants of the attitude sensor fusion block.
// Fixed-point coefficients, reciprocal constants and the port structures.
// Depends on nothing; every other file of the block imports it.
package attsf_pkg;

   // Fixed-point format of the filter and fusion state.
   localparam int FRAC_BITS = 14;
   localparam longint ONE = longint'(1) << FRAC_BITS;

   // Coefficients are given at 14 fractional bits and rescaled, truncating.
   localparam longint CO_B1   = (-6763 * ONE) / 16384;
   localparam longint CO_B2   = (18727 * ONE) / 16384;
   localparam longint CO_GAIN = (242890 * ONE) / 16384;
   localparam longint CO_KR   = (377 * ONE) / 16384;

   // Raw samples are divided by 64 before the gain division.
   localparam int RAW_W     = 16;
   localparam int PRE_SHIFT = 6;
   localparam int SMAG_W    = RAW_W - PRE_SHIFT;
   localparam int NG_W      = SMAG_W + 2 * FRAC_BITS;

   // Reciprocals for the divisions by constants. The estimate is at most one
   // below the true quotient, and a single correction step fixes it.
   localparam int     GAIN_SHIFT = 12;
   localparam longint GAIN_RECIP = (longint'(1) << (2 * FRAC_BITS + GAIN_SHIFT)) / CO_GAIN;
   localparam longint BIAS_DIV   = 1000;
   localparam longint BIAS_DIV2  = BIAS_DIV * BIAS_DIV;
   localparam int     BIAS_SHIFT = 50;
   localparam longint BIAS_RECIP = (longint'(1) << BIAS_SHIFT) / BIAS_DIV2;

   // Shared multiplier size.
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   // Stream word widths.
   localparam int ANGLE_W = 18;
   localparam int REQ_W   = 80;
   localparam int RSP_W   = 136;

   typedef struct packed {
      logic signed [RAW_W-1:0] accel_y;
      logic signed [RAW_W-1:0] accel_x;
      logic signed [RAW_W-1:0] yaw_rate_raw;
      logic signed [RAW_W-1:0] pitch_rate_raw;
      logic signed [RAW_W-1:0] roll_rate_raw;
   } attsf_sample_type;

   typedef struct packed {
      logic signed [31:0]        yaw_rate_filtered;
      logic signed [31:0]        pitch_rate_corr;
      logic signed [31:0]        roll_rate_corr;
      logic signed [ANGLE_W-1:0] pitch_angle;
      logic signed [ANGLE_W-1:0] roll_angle;
   } attsf_result_type;

   typedef struct packed {
      logic start;
      logic out_free;
   } attsf_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } attsf_sts_type;

   typedef struct packed {
      logic signed [31:0] x_old;
      logic signed [31:0] x_new;
      logic signed [31:0] y_old;
      logic signed [31:0] y_new;
   } attsf_hist_type;

endpackage

// File: hdl/attsf_mul.sv
// Shared signed multiplier with a registered product.
// Depends on attsf_pkg for the operand and product widths.
module attsf_mul (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [attsf_pkg::MUL_W-1:0]  a,
   input  logic signed [attsf_pkg::MUL_W-1:0]  b,
   output logic signed [attsf_pkg::PROD_W-1:0] prod
);
   import attsf_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = a * b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// File: hdl/attsf_core.sv
// Sequencer and datapath of the attitude sensor fusion block: three biquads
// and two complementary filters, all products through one attsf_mul.
// Depends on attsf_pkg and attsf_mul.
module attsf_core (
   input  logic                         clock,
   input  logic                         reset,
   input  attsf_pkg::attsf_ctl_type     ctl,
   input  attsf_pkg::attsf_sample_type  sample,
   output attsf_pkg::attsf_sts_type     sts,
   output attsf_pkg::attsf_result_type  result
);
   import attsf_pkg::*;

   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] ST_IDLE   = 5'd0;
   localparam logic [ST_W-1:0] ST_G_MUL1 = 5'd1;
   localparam logic [ST_W-1:0] ST_G_Q0   = 5'd2;
   localparam logic [ST_W-1:0] ST_G_MUL2 = 5'd3;
   localparam logic [ST_W-1:0] ST_G_FIX  = 5'd4;
   localparam logic [ST_W-1:0] ST_B_MUL1 = 5'd5;
   localparam logic [ST_W-1:0] ST_B_T1   = 5'd6;
   localparam logic [ST_W-1:0] ST_B_MUL2 = 5'd7;
   localparam logic [ST_W-1:0] ST_B_T2   = 5'd8;
   localparam logic [ST_W-1:0] ST_B_END  = 5'd9;
   localparam logic [ST_W-1:0] ST_F_R    = 5'd10;
   localparam logic [ST_W-1:0] ST_F_MUL1 = 5'd11;
   localparam logic [ST_W-1:0] ST_F_T    = 5'd12;
   localparam logic [ST_W-1:0] ST_F_A    = 5'd13;
   localparam logic [ST_W-1:0] ST_F_D1   = 5'd14;
   localparam logic [ST_W-1:0] ST_F_AC   = 5'd15;
   localparam logic [ST_W-1:0] ST_F_D2   = 5'd16;
   localparam logic [ST_W-1:0] ST_F_ABS  = 5'd17;
   localparam logic [ST_W-1:0] ST_F_MUL2 = 5'd18;
   localparam logic [ST_W-1:0] ST_F_Q0   = 5'd19;
   localparam logic [ST_W-1:0] ST_F_MUL3 = 5'd20;
   localparam logic [ST_W-1:0] ST_F_FIX  = 5'd21;
   localparam logic [ST_W-1:0] ST_F_END  = 5'd22;
   localparam logic [ST_W-1:0] ST_DONE   = 5'd23;

   localparam logic [1:0] LAST_FILT = 2'd2;

   // Truncating division of a product by 2^FRAC_BITS, kept to 32 bits.
   function automatic logic signed [31:0] qdiv(input logic signed [PROD_W-1:0] p);
      logic [FRAC_BITS+31:0] low;
      logic [FRAC_BITS+31:0] sum;
      low = p[FRAC_BITS+31:0];
      sum = low + (p[PROD_W-1] ? {{32{1'b0}}, {FRAC_BITS{1'b1}}} : '0);
      return $signed(sum[FRAC_BITS+31:FRAC_BITS]);
   endfunction

   // Integer part of a Q angle, rounded toward zero.
   function automatic logic signed [ANGLE_W-1:0] qint(input logic signed [31:0] v);
      logic signed [31:0] sum;
      logic signed [31:0] shifted;
      sum     = v + (v[31] ? 32'(ONE - 1) : 32'sd0);
      shifted = sum >>> FRAC_BITS;
      return shifted[ANGLE_W-1:0];
   endfunction

   logic [ST_W-1:0]       state_ff, state_in;
   logic [1:0]            filt_ff, filt_in;
   logic                  axis_ff, axis_in;
   attsf_sample_type      smp_ff, smp_in;

   // Histories rotate after each biquad so the active filter always sits in
   // entry 0; after all three the original order is back.
   attsf_hist_type        hist_ff [3];
   attsf_hist_type        hist_in [3];
   // Angle and bias rotate the same way between the two axes.
   logic signed [31:0]    ang_ff [2];
   logic signed [31:0]    ang_in [2];
   logic signed [31:0]    bias_ff [2];
   logic signed [31:0]    bias_in [2];
   logic signed [31:0]    rout_ff [2];
   logic signed [31:0]    rout_in [2];

   logic [31:0]           q_ff, q_in;
   logic signed [31:0]    xn_ff, xn_in;
   logic signed [31:0]    acc_ff, acc_in;
   logic signed [31:0]    term_ff, term_in;
   logic signed [31:0]    rcur_ff, rcur_in;
   logic signed [31:0]    a_ff, a_in;
   logic signed [31:0]    d_ff, d_in;
   logic [31:0]           dmag_ff, dmag_in;
   logic                  dneg_ff, dneg_in;

   logic                      done_pulse;
   logic                      mul_en;
   logic signed [MUL_W-1:0]   mul_a;
   logic signed [MUL_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]  prod;

   logic signed [RAW_W-1:0]   raw_sel;
   logic signed [RAW_W-1:0]   raw_shr;
   logic [SMAG_W-1:0]         smag;
   logic                      sneg;
   logic [NG_W-1:0]           gain_num;
   logic [NG_W-1:0]           gain_rem;
   logic [32:0]               bias_rem;
   logic signed [RAW_W-1:0]   rate_sel;
   logic signed [31:0]        rate_q;
   logic signed [31:0]        ref_sel;
   logic signed [31:0]        dq;

   attsf_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   always_comb begin
      case (filt_ff)
         2'd0:    raw_sel = smp_ff.yaw_rate_raw;
         2'd1:    raw_sel = smp_ff.accel_x;
         default: raw_sel = smp_ff.accel_y;
      endcase
   end

   // Floor division by 64, then sign and magnitude of the scaled input.
   assign raw_shr  = raw_sel >>> PRE_SHIFT;
   assign sneg     = raw_sel[RAW_W-1];
   assign smag     = sneg ? (~raw_shr[SMAG_W-1:0] + 1'b1) : raw_shr[SMAG_W-1:0];
   assign gain_num = {smag, {(2 * FRAC_BITS){1'b0}}};
   assign gain_rem = gain_num - prod[NG_W-1:0];
   assign bias_rem = {1'b0, dmag_ff} - prod[32:0];

   assign rate_sel = axis_ff ? smp_ff.pitch_rate_raw : smp_ff.roll_rate_raw;
   assign rate_q   = 32'(rate_sel) <<< FRAC_BITS;
   // Roll follows the filtered Y acceleration, pitch the filtered X one.
   assign ref_sel  = axis_ff ? hist_ff[1].y_new : hist_ff[2].y_new;
   assign dq       = dneg_ff ? -$signed(q_ff) : $signed(q_ff);

   always_comb begin
      state_in   = state_ff;
      filt_in    = filt_ff;
      axis_in    = axis_ff;
      smp_in     = smp_ff;
      hist_in    = hist_ff;
      ang_in     = ang_ff;
      bias_in    = bias_ff;
      rout_in    = rout_ff;
      q_in       = q_ff;
      xn_in      = xn_ff;
      acc_in     = acc_ff;
      term_in    = term_ff;
      rcur_in    = rcur_ff;
      a_in       = a_ff;
      d_in       = d_ff;
      dmag_in    = dmag_ff;
      dneg_in    = dneg_ff;
      mul_en     = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      done_pulse = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               smp_in   = sample;
               filt_in  = 2'd0;
               axis_in  = 1'b0;
               state_in = ST_G_MUL1;
            end
         end
         ST_G_MUL1: begin
            mul_en   = 1'b1;
            mul_a    = $signed({{(MUL_W - SMAG_W){1'b0}}, smag});
            mul_b    = MUL_W'(GAIN_RECIP);
            state_in = ST_G_Q0;
         end
         ST_G_Q0: begin
            q_in     = prod[GAIN_SHIFT+31:GAIN_SHIFT];
            state_in = ST_G_MUL2;
         end
         ST_G_MUL2: begin
            mul_en   = 1'b1;
            mul_a    = $signed({1'b0, q_ff});
            mul_b    = MUL_W'(CO_GAIN);
            state_in = ST_G_FIX;
         end
         ST_G_FIX: begin
            if (gain_rem >= NG_W'(CO_GAIN)) begin
               q_in = q_ff + 32'd1;
            end
            state_in = ST_B_MUL1;
         end
         ST_B_MUL1: begin
            xn_in    = sneg ? -$signed(q_ff) : $signed(q_ff);
            mul_en   = 1'b1;
            mul_a    = MUL_W'(CO_B1);
            mul_b    = MUL_W'(hist_ff[0].y_old);
            state_in = ST_B_T1;
         end
         ST_B_T1: begin
            term_in  = qdiv(prod);
            // The feed-forward taps are exact multiples of one.
            acc_in   = hist_ff[0].x_old + (hist_ff[0].x_new <<< 1) + xn_ff;
            state_in = ST_B_MUL2;
         end
         ST_B_MUL2: begin
            acc_in   = acc_ff + term_ff;
            mul_en   = 1'b1;
            mul_a    = MUL_W'(CO_B2);
            mul_b    = MUL_W'(hist_ff[0].y_new);
            state_in = ST_B_T2;
         end
         ST_B_T2: begin
            term_in  = qdiv(prod);
            state_in = ST_B_END;
         end
         ST_B_END: begin
            hist_in[0]       = hist_ff[1];
            hist_in[1]       = hist_ff[2];
            hist_in[2].x_old = hist_ff[0].x_new;
            hist_in[2].x_new = xn_ff;
            hist_in[2].y_old = hist_ff[0].y_new;
            hist_in[2].y_new = acc_ff + term_ff;
            if (filt_ff == LAST_FILT) begin
               filt_in  = 2'd0;
               state_in = ST_F_R;
            end else begin
               filt_in  = filt_ff + 2'd1;
               state_in = ST_G_MUL1;
            end
         end
         ST_F_R: begin
            rcur_in  = rate_q - bias_ff[0];
            state_in = ST_F_MUL1;
         end
         ST_F_MUL1: begin
            mul_en   = 1'b1;
            mul_a    = MUL_W'(rcur_ff);
            mul_b    = MUL_W'(CO_KR);
            state_in = ST_F_T;
         end
         ST_F_T: begin
            term_in  = qdiv(prod);
            state_in = ST_F_A;
         end
         ST_F_A: begin
            a_in     = ang_ff[0] + term_ff;
            state_in = ST_F_D1;
         end
         ST_F_D1: begin
            d_in     = a_ff - ref_sel;
            state_in = ST_F_AC;
         end
         ST_F_AC: begin
            // The correction gain is one eighth, divided toward zero.
            a_in     = a_ff - ((d_ff + (d_ff[31] ? 32'sd7 : 32'sd0)) >>> 3);
            state_in = ST_F_D2;
         end
         ST_F_D2: begin
            d_in     = a_ff - ref_sel;
            state_in = ST_F_ABS;
         end
         ST_F_ABS: begin
            dneg_in  = d_ff[31];
            dmag_in  = d_ff[31] ? -d_ff : d_ff;
            state_in = ST_F_MUL2;
         end
         ST_F_MUL2: begin
            mul_en   = 1'b1;
            mul_a    = $signed({1'b0, dmag_ff});
            mul_b    = MUL_W'(BIAS_RECIP);
            state_in = ST_F_Q0;
         end
         ST_F_Q0: begin
            q_in     = 32'(prod[PROD_W-2:BIAS_SHIFT]);
            state_in = ST_F_MUL3;
         end
         ST_F_MUL3: begin
            mul_en   = 1'b1;
            mul_a    = $signed({1'b0, q_ff});
            mul_b    = MUL_W'(BIAS_DIV2);
            state_in = ST_F_FIX;
         end
         ST_F_FIX: begin
            if (bias_rem >= 33'(BIAS_DIV2)) begin
               q_in = q_ff + 32'd1;
            end
            state_in = ST_F_END;
         end
         ST_F_END: begin
            ang_in[0]        = ang_ff[1];
            ang_in[1]        = a_ff;
            bias_in[0]       = bias_ff[1];
            bias_in[1]       = bias_ff[0] + dq;
            rout_in[axis_ff] = rcur_ff;
            if (axis_ff) begin
               state_in = ST_DONE;
            end else begin
               axis_in  = 1'b1;
               state_in = ST_F_R;
            end
         end
         ST_DONE: begin
            if (ctl.out_free) begin
               done_pulse = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign sts.idle = (state_ff == ST_IDLE);
   assign sts.done = done_pulse;

   assign result.roll_angle        = qint(ang_ff[0]);
   assign result.pitch_angle       = qint(ang_ff[1]);
   assign result.roll_rate_corr    = rout_ff[0];
   assign result.pitch_rate_corr   = rout_ff[1];
   assign result.yaw_rate_filtered = hist_ff[0].y_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         filt_ff  <= 2'd0;
         axis_ff  <= 1'b0;
         hist_ff  <= '{default: '0};
         ang_ff   <= '{default: '0};
         bias_ff  <= '{default: '0};
      end else begin
         state_ff <= state_in;
         filt_ff  <= filt_in;
         axis_ff  <= axis_in;
         hist_ff  <= hist_in;
         ang_ff   <= ang_in;
         bias_ff  <= bias_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff  <= smp_in;
      rout_ff <= rout_in;
      q_ff    <= q_in;
      xn_ff   <= xn_in;
      acc_ff  <= acc_in;
      term_ff <= term_in;
      rcur_ff <= rcur_in;
      a_ff    <= a_in;
      d_ff    <= d_in;
      dmag_ff <= dmag_in;
      dneg_ff <= dneg_in;
   end

endmodule

// File: hdl/attitude_sensor_fusion.sv
// Attitude sensor fusion: one raw IMU sample per input word gives one word of
// fused roll and pitch angles, bias-corrected rates and filtered yaw rate.
// The three low-pass biquads (yaw rate, X and Y acceleration) and the two
// complementary filters run in sequence on one shared 33 by 33 multiplier,
// stepped by a small sequencer; every product is followed by a step that shifts,
// corrects or accumulates it. The block finishes each accepted sample, with
// eighteen products, each with its follow-up step, plus the add and compare
// steps of the fusion, before it takes the next one. req_tready is high only
// while the sequencer is idle. A finished result waits in the output register,
// so the next sample is taken while the previous result has not yet been read.
// Depends on attsf_pkg and attsf_core.
module attitude_sensor_fusion (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // roll_rate_raw, pitch_rate_raw, yaw_rate_raw, accel_x, accel_y (16 bits each)
   input  logic [attsf_pkg::REQ_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // roll_angle (18), pitch_angle (18), roll_rate_corr (32), pitch_rate_corr (32),
   // yaw_rate_filtered (32), four zero bits
   output logic [attsf_pkg::RSP_W-1:0] rsp_tdata
);
   import attsf_pkg::*;

   localparam int RES_W = $bits(attsf_result_type);

   attsf_ctl_type    ctl;
   attsf_sts_type    sts;
   attsf_sample_type sample;
   attsf_result_type result;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   assign sample     = req_tdata;
   assign req_tready = sts.idle;
   assign ctl.start  = req_tvalid & sts.idle;
   assign ctl.out_free = ~rsp_valid_ff | rsp_tready;

   attsf_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (sample),
      .sts    (sts),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (sts.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_W - RES_W){1'b0}}, result};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for attitude_sensor_fusion: drives raw IMU words with bursty
// timing, checks each result field by field against its fixed-point model or a known answer.
// Depends on attsf_pkg and the attitude_sensor_fusion RTL.
module testbench;
   import attsf_pkg::*;

   localparam int     CLOCK_HALF    = 4;
   localparam int     CYCLE_LIMIT   = 1_000_000;
   localparam int     TOTAL_SAMPLES = 1150;
   localparam int     DRAIN_CYCLES  = 80;
   localparam int     HOLD_CYCLES   = 600;
   localparam int     HOLD_AFTER    = 150;
   localparam int     RESULT_BITS   = $bits(attsf_result_type);
   localparam int     RAW_SHIFT     = 6;

   // Filter and fusion coefficients, rescaled from 14 fractional bits.
   localparam longint Q_ONE   = longint'(1) << FRAC_BITS;
   localparam longint LP_A0   = (longint'(16384) * Q_ONE) / 16384;
   localparam longint LP_A1   = (longint'(32768) * Q_ONE) / 16384;
   localparam longint LP_A2   = (longint'(16384) * Q_ONE) / 16384;
   localparam longint LP_B1   = (longint'(-6763) * Q_ONE) / 16384;
   localparam longint LP_B2   = (longint'(18727) * Q_ONE) / 16384;
   localparam longint LP_GAIN = (longint'(242890) * Q_ONE) / 16384;
   localparam longint FUSE_KR = (longint'(377) * Q_ONE) / 16384;
   localparam longint FUSE_C1 = (longint'(131072) * Q_ONE) / 16384;
   localparam longint BIAS_STEP = 1000;

   typedef enum int {SPAN_FULL, SPAN_EDGE, SPAN_SMALL} span_kind_t;

   typedef struct {
      bit               known;
      attsf_result_type value;
   } fixed_answer_t;

   localparam int DIRECTED_ROWS = 20;
   localparam int KNOWN_ROWS    = 3;

   // roll, pitch, yaw, accel_x, accel_y
   int directed_stim [DIRECTED_ROWS][5] = '{
      '{0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0},
      '{0, -1, 0, 0, 0},
      '{32767, 32767, 32767, 32767, 32767},
      '{-32768, -32768, -32768, -32768, -32768},
      '{-32768, 32767, -1, -1, -1},
      '{0, 0, -63, -64, -65},
      '{0, 0, 63, 64, 65},
      '{0, 0, -32768, 32767, -32768},
      '{32767, 32767, 32767, -32768, -32768},
      '{32767, 32767, 32767, -32768, -32768},
      '{32767, 32767, 32767, -32768, -32768},
      '{32767, 32767, 32767, -32768, -32768},
      '{32767, 32767, 32767, -32768, -32768},
      '{32767, 32767, 32767, -32768, -32768},
      '{-1, -1, -1, -1, -1},
      '{0, 0, 0, 0, 0},
      '{21845, -21846, 21845, -21846, 21845},
      '{-21846, 21845, -21846, 21845, -21846},
      '{1, 1, 1, 1, 1}
   };

   // roll_angle, pitch_angle, roll_rate_corr, pitch_rate_corr, yaw_rate_filtered
   int directed_known [KNOWN_ROWS][5] = '{
      '{0, 0, 0, 0, 0},
      '{0, 0, 16384, 0, 0},
      '{0, 0, 0, -16384, 0}
   };

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;

   // Predictor state: filter histories (older, newer per filter), angles and biases.
   int lp_x_hist [6];
   int lp_y_hist [6];
   int angle_state [2];
   int bias_state [2];

   attsf_result_type attitude_q [$];
   fixed_answer_t    fixed_answer_q [$];
   int               fault_count;
   int               results_checked;
   int               samples_sent;
   int               burst_left;
   int               cycle_count;

   attitude_sensor_fusion uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #CLOCK_HALF clock = ~clock;

   function automatic longint fx_mul(input longint a, input longint b);
      return (a * b) / Q_ONE;
   endfunction

   function automatic int lowpass_step(input int f, input logic signed [15:0] raw);
      longint scaled;
      longint acc;
      int     xn;
      int     y;
      // The pre-scale is an arithmetic shift, so negative samples round down.
      scaled = longint'(raw) >>> RAW_SHIFT;
      xn = int'((scaled * Q_ONE * Q_ONE) / LP_GAIN);
      acc = fx_mul(LP_A0, lp_x_hist[2*f]) + fx_mul(LP_A1, lp_x_hist[2*f+1])
          + fx_mul(LP_A2, xn) + fx_mul(LP_B1, lp_y_hist[2*f])
          + fx_mul(LP_B2, lp_y_hist[2*f+1]);
      y = int'(acc);
      lp_x_hist[2*f]   = lp_x_hist[2*f+1];
      lp_x_hist[2*f+1] = xn;
      lp_y_hist[2*f]   = lp_y_hist[2*f+1];
      lp_y_hist[2*f+1] = y;
      return y;
   endfunction

   function automatic int fuse_axis(input int k, input longint rate, input int ref_angle);
      int r;
      int a;
      int d;
      int d2;
      r = int'(rate * Q_ONE - longint'(bias_state[k]));
      a = int'(longint'(angle_state[k]) + fx_mul(r, FUSE_KR));
      d = int'(longint'(a) - longint'(ref_angle));
      a = int'(longint'(a) - longint'(int'((longint'(d) * Q_ONE) / FUSE_C1)));
      // The bias follows the error left after the angle correction.
      d2 = int'(longint'(a) - longint'(ref_angle));
      bias_state[k] = int'(longint'(bias_state[k])
                           + (longint'(d2) / BIAS_STEP) / BIAS_STEP);
      angle_state[k] = a;
      return r;
   endfunction

   function automatic attsf_result_type predict_attitude(input attsf_sample_type s);
      attsf_result_type res;
      int     yaw_lp;
      int     ax_lp;
      int     ay_lp;
      longint roll_whole;
      longint pitch_whole;
      yaw_lp = lowpass_step(0, s.yaw_rate_raw);
      ax_lp  = lowpass_step(1, s.accel_x);
      ay_lp  = lowpass_step(2, s.accel_y);
      res.roll_rate_corr    = fuse_axis(0, longint'(s.roll_rate_raw), ay_lp);
      res.pitch_rate_corr   = fuse_axis(1, longint'(s.pitch_rate_raw), ax_lp);
      res.yaw_rate_filtered = yaw_lp;
      roll_whole  = longint'(angle_state[0]) / Q_ONE;
      pitch_whole = longint'(angle_state[1]) / Q_ONE;
      res.roll_angle  = roll_whole[ANGLE_W-1:0];
      res.pitch_angle = pitch_whole[ANGLE_W-1:0];
      return res;
   endfunction

   function automatic logic [15:0] draw_field(input span_kind_t kind);
      logic [15:0] corners [9] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF,
                                   16'hFFC0, 16'hFFBF, 16'h003F, 16'h0040};
      case (kind)
         SPAN_EDGE:  return corners[$urandom_range(0, 8)];
         SPAN_SMALL: return 16'($urandom_range(0, 511)) - 16'd256;
         default:    return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic attsf_sample_type draw_sample(input span_kind_t kind);
      attsf_sample_type s;
      s.roll_rate_raw  = draw_field(kind);
      s.pitch_rate_raw = draw_field(kind);
      s.yaw_rate_raw   = draw_field(kind);
      s.accel_x        = draw_field(kind);
      s.accel_y        = draw_field(kind);
      return s;
   endfunction

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fault_count++;
      end
   endfunction

   // Offers one word and returns once it is taken; closes a burst with a random gap.
   task automatic offer_sample(input attsf_sample_type s, input bit known,
                               input attsf_result_type answer);
      fixed_answer_t fa;
      int gap;
      fa.known = known;
      fa.value = answer;
      fixed_answer_q.push_back(fa);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(s);
      do @(posedge clock); while (!req_tready);
      samples_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      fixed_answer_t    fa;
      attsf_result_type want;
      attsf_result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            fa   = fixed_answer_q.pop_front();
            want = predict_attitude(attsf_sample_type'(req_tdata));
            if (fa.known)
               want = fa.value;
            attitude_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (attitude_q.size() == 0) begin
               $error("result word arrived with no sample pending");
               fault_count++;
            end else begin
               want = attitude_q.pop_front();
               got  = attsf_result_type'(rsp_tdata[RESULT_BITS-1:0]);
               check_field("roll_angle", want.roll_angle, got.roll_angle);
               check_field("pitch_angle", want.pitch_angle, got.pitch_angle);
               check_field("roll_rate_corr", want.roll_rate_corr, got.roll_rate_corr);
               check_field("pitch_rate_corr", want.pitch_rate_corr, got.pitch_rate_corr);
               check_field("yaw_rate_filtered", want.yaw_rate_filtered,
                           got.yaw_rate_filtered);
               check_field("pad", 0, longint'(rsp_tdata[RSP_W-1:RESULT_BITS]));
            end
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side: ready runs, stall runs and random ready, plus one long hold-off
   // that lets the block fill up and back-pressure the sample side.
   initial begin : receiver
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && results_checked >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         case ($urandom_range(0, 3))
            0: begin
               rsp_tready <= 1'b1;
               repeat ($urandom_range(20, 200)) @(posedge clock);
            end
            1: begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(1, 40)) @(posedge clock);
            end
            default: begin
               repeat ($urandom_range(10, 60)) begin
                  rsp_tready <= ($urandom_range(0, 2) != 0);
                  @(posedge clock);
               end
            end
         endcase
      end
   end

   initial begin : stimulus
      attsf_sample_type s;
      attsf_sample_type base;
      attsf_result_type answer;
      bit               known;
      int               run_len;
      clock           = 1'b0;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      fault_count     = 0;
      results_checked = 0;
      samples_sent    = 0;
      cycle_count     = 0;
      burst_left      = $urandom_range(1, 30);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         s.roll_rate_raw  = directed_stim[i][0][15:0];
         s.pitch_rate_raw = directed_stim[i][1][15:0];
         s.yaw_rate_raw   = directed_stim[i][2][15:0];
         s.accel_x        = directed_stim[i][3][15:0];
         s.accel_y        = directed_stim[i][4][15:0];
         known  = (i < KNOWN_ROWS);
         answer = '0;
         if (known) begin
            answer.roll_angle        = directed_known[i][0][ANGLE_W-1:0];
            answer.pitch_angle       = directed_known[i][1][ANGLE_W-1:0];
            answer.roll_rate_corr    = directed_known[i][2];
            answer.pitch_rate_corr   = directed_known[i][3];
            answer.yaw_rate_filtered = directed_known[i][4];
         end
         offer_sample(s, known, answer);
      end

      // Steady runs let the filters settle and the biases drift; the rest is
      // independent words, corner values and small values around zero.
      while (samples_sent < TOTAL_SAMPLES) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               base    = draw_sample(($urandom_range(0, 2) == 0) ? SPAN_EDGE : SPAN_FULL);
               run_len = $urandom_range(5, 40);
               for (int j = 0; j < run_len && samples_sent < TOTAL_SAMPLES; j++) begin
                  s = base;
                  s.roll_rate_raw  = base.roll_rate_raw + 16'($urandom_range(0, 64)) - 16'd32;
                  s.pitch_rate_raw = base.pitch_rate_raw + 16'($urandom_range(0, 64)) - 16'd32;
                  s.yaw_rate_raw   = base.yaw_rate_raw + 16'($urandom_range(0, 64)) - 16'd32;
                  s.accel_x        = base.accel_x + 16'($urandom_range(0, 64)) - 16'd32;
                  s.accel_y        = base.accel_y + 16'($urandom_range(0, 64)) - 16'd32;
                  offer_sample(s, 1'b0, '0);
               end
            end
            5, 6, 7: begin
               run_len = $urandom_range(1, 20);
               for (int j = 0; j < run_len && samples_sent < TOTAL_SAMPLES; j++)
                  offer_sample(draw_sample(SPAN_FULL), 1'b0, '0);
            end
            8: offer_sample(draw_sample(SPAN_EDGE), 1'b0, '0);
            default: offer_sample(draw_sample(SPAN_SMALL), 1'b0, '0);
         endcase
      end
      req_tvalid <= 1'b0;

      while (attitude_q.size() != 0 || fixed_answer_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: filelist.f
hdl/attsf_pkg.sv
hdl/attsf_mul.sv
hdl/attsf_core.sv
hdl/attitude_sensor_fusion.sv
tb/testbench.sv
